@@ rtl/core/idiv_pkg.sv @@
// Shared types and constants of the pipelined integer divider.
// Used by every module in rtl/core; depends on nothing else.
package idiv_pkg;

  localparam int unsigned DVD_W           = 32;
  localparam int unsigned DSR_W           = 16;
  localparam int unsigned STEPS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES      = DVD_W / STEPS_PER_STAGE;

  // Payload that travels down the divide stages.
  typedef struct packed {
    logic [DVD_W-1:0] dvd;     // dividend bits not yet consumed, quotient shifted in
    logic [DSR_W-1:0] rem;     // partial remainder, below the divisor unless the divisor is zero
    logic [DSR_W-1:0] dsr;     // divisor magnitude
    logic             size;    // 1 word, 0 byte
    logic             q_neg;
    logic             r_neg;
    logic             dz;      // divisor is zero
    logic [31:0]      dz_res;  // packed result for a zero divisor
  } idiv_stage_t;

endpackage

@@ rtl/core/idiv_prep.sv @@
// Entry stage: sign handling, magnitudes and the zero divisor case.
// Depends on idiv_pkg.
module idiv_prep (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic                kind_i,
  input  logic                size_i,
  input  logic [31:0]         dividend_i,
  input  logic [15:0]         divisor_i,
  output logic                valid_o,
  input  logic                ready_i,
  output idiv_pkg::idiv_stage_t data_o
);
  import idiv_pkg::*;

  logic             valid_q;
  idiv_stage_t      data_q, data_d;
  logic [DVD_W-1:0] dfull;
  logic [DSR_W-1:0] sfull;
  logic             dneg, sneg;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    // Byte operands are sign or zero extended to the word width first.
    dfull = size_i ? dividend_i : {{16{kind_i & dividend_i[15]}}, dividend_i[15:0]};
    sfull = size_i ? divisor_i  : {{8{kind_i & divisor_i[7]}}, divisor_i[7:0]};
    dneg  = kind_i & dfull[DVD_W-1];
    sneg  = kind_i & sfull[DSR_W-1];
    data_d.dvd    = dneg ? (~dfull + 1'b1) : dfull;
    data_d.rem    = '0;
    data_d.dsr    = sneg ? (~sfull + 1'b1) : sfull;
    data_d.size   = size_i;
    data_d.q_neg  = dneg ^ sneg;
    data_d.r_neg  = dneg;
    data_d.dz     = (sfull == '0);
    data_d.dz_res = size_i ? {dividend_i[15:0], ~dividend_i[31:16]}
                           : {16'b0, dividend_i[7:0], ~dividend_i[15:8]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  a_zero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o && (size_i ? (divisor_i == '0) : (divisor_i[7:0] == '0))
    |=> valid_q && data_q.dz)
    else $error("zero divisor not marked at entry");

endmodule

@@ rtl/core/idiv_step.sv @@
// One divide stage: several restoring steps on the magnitudes, then a register.
// Depends on idiv_pkg.
module idiv_step (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  idiv_pkg::idiv_stage_t data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output idiv_pkg::idiv_stage_t data_o
);
  import idiv_pkg::*;

  logic        valid_q;
  idiv_stage_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    logic [DSR_W:0] trial;
    logic           qbit;
    data_d = data_i;
    for (int unsigned k = 0; k < STEPS_PER_STAGE; k++) begin
      trial = {data_d.rem, data_d.dvd[DVD_W-1]};
      if (trial >= {1'b0, data_d.dsr}) begin
        data_d.rem = DSR_W'(trial - {1'b0, data_d.dsr});
        qbit       = 1'b1;
      end else begin
        data_d.rem = trial[DSR_W-1:0];
        qbit       = 1'b0;
      end
      data_d.dvd = {data_d.dvd[DVD_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !data_q.dz |-> data_q.rem < data_q.dsr)
    else $error("partial remainder not below divisor");

endmodule

@@ rtl/core/idiv_fin.sv @@
// Final stage: restores signs, packs the result and drives the output register.
// Depends on idiv_pkg.
module idiv_fin (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  idiv_pkg::idiv_stage_t data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [31:0]           result_o,
  output logic                  overflow_o
);
  import idiv_pkg::*;

  logic        valid_q;
  logic [31:0] result_q, result_d;
  logic        ovf_q, ovf_d;
  logic [15:0] quo, rem;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    quo = data_i.q_neg ? (~data_i.dvd[15:0] + 1'b1) : data_i.dvd[15:0];
    rem = data_i.r_neg ? (~data_i.rem + 1'b1) : data_i.rem;
    if (data_i.dz) begin
      result_d = data_i.dz_res;
      ovf_d    = 1'b1;
    end else begin
      result_d = data_i.size ? {rem, quo} : {16'b0, rem[7:0], quo[7:0]};
      // A negative remainder has its upper bits set at double width.
      ovf_d    = data_i.r_neg && (data_i.rem != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      result_q <= result_d;
      ovf_q    <= ovf_d;
    end
  end

  assign valid_o    = valid_q;
  assign result_o   = result_q;
  assign overflow_o = ovf_q;

  a_byte_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o && !data_i.size |=> result_q[31:16] == '0)
    else $error("byte result has upper bits set");

endmodule

@@ rtl/core/integer_divider_with_flags.sv @@
// Top level of the pipelined 32 by 16 integer divider with overflow flag.
// Depends on idiv_pkg, idiv_prep, idiv_step and idiv_fin.
//
//   channel   direction  tdata                              tuser
//   s_axis    in         dividend[31:0], divisor[47:32]     kind[0], size[1]
//   m_axis    out        packed_result[31:0]                overflow
//
// One transfer per cycle unless the output stalls; the path is one entry stage,
// eight divide stages of four restoring steps each, and the output register.
// The restoring step chain inside each divide stage sets the clock period.
// Reset empties every stage. Each stage holds only while it is full and its
// successor cannot take its data, so a stall fills bubbles behind it.
module integer_divider_with_flags (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // dividend[31:0], divisor[47:32]
  input  logic [1:0]  s_axis_tuser,   // kind[0], size[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // packed_result[31:0]
  output logic        m_axis_tuser    // overflow
);
  import idiv_pkg::*;

  logic        valid_s [DIV_STAGES+1];
  logic        ready_s [DIV_STAGES+1];
  idiv_stage_t data_s  [DIV_STAGES+1];

  idiv_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .kind_i     (s_axis_tuser[0]),
    .size_i     (s_axis_tuser[1]),
    .dividend_i (s_axis_tdata[31:0]),
    .divisor_i  (s_axis_tdata[47:32]),
    .valid_o    (valid_s[0]),
    .ready_i    (ready_s[0]),
    .data_o     (data_s[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_step
    idiv_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[g]),
      .ready_o (ready_s[g]),
      .data_i  (data_s[g]),
      .valid_o (valid_s[g+1]),
      .ready_i (ready_s[g+1]),
      .data_o  (data_s[g+1])
    );
  end

  idiv_fin u_fin (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_s[DIV_STAGES]),
    .ready_o    (ready_s[DIV_STAGES]),
    .data_i     (data_s[DIV_STAGES]),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .result_o   (m_axis_tdata),
    .overflow_o (m_axis_tuser)
  );

  // With the output register empty, every stage ahead of it can move.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output stage is empty");

  a_full_pipe_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input blocked without an output stall");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for integer_divider_with_flags: directed and random divides
// over the stream ports, checked against typed results or a behavioral divide model.
// Depends on the RTL top level only.
module testbench;

  localparam logic KIND_UNSIGNED = 1'b0;
  localparam logic KIND_SIGNED   = 1'b1;
  localparam logic SIZE_BYTE     = 1'b0;
  localparam logic SIZE_WORD     = 1'b1;

  localparam int N_RANDOM    = 1930;
  localparam int RX_HOLD     = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_DIR       = 22;

  typedef struct packed {
    logic [31:0] res;
    logic        ov;
  } div_out_t;

  typedef struct packed {
    logic        kind;
    logic        size;
    logic [31:0] dvd;
    logic [15:0] dsr;
    bit          typed;
    logic [31:0] res;
    logic        ov;
  } div_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  div_out_t quot_rem_due[$];
  bit       drv_typed;
  div_out_t drv_want;
  bit       tx_burst;
  bit       rx_burst;
  bit       rx_hold_req;
  int       mismatches;
  int       cycles;

  // Rows with a typed result cover zero divisors, extremes and wrapping quotients.
  div_row_t div_rows [N_DIR] = '{
    '{KIND_UNSIGNED, SIZE_BYTE, 32'h0000_0064, 16'h0007, 1'b1, 32'h0000_020E, 1'b0},
    '{KIND_UNSIGNED, SIZE_BYTE, 32'hABCD_0064, 16'h1207, 1'b1, 32'h0000_020E, 1'b0},
    '{KIND_UNSIGNED, SIZE_BYTE, 32'h0000_1234, 16'h0000, 1'b1, 32'h0000_34ED, 1'b1},
    '{KIND_SIGNED,   SIZE_WORD, 32'hDEAD_BEEF, 16'h0000, 1'b1, 32'hBEEF_2152, 1'b1},
    '{KIND_UNSIGNED, SIZE_BYTE, 32'hFFFF_0000, 16'hFF00, 1'b1, 32'h0000_00FF, 1'b1},
    '{KIND_SIGNED,   SIZE_BYTE, 32'h0000_FFFF, 16'h0000, 1'b1, 32'h0000_FF00, 1'b1},
    '{KIND_UNSIGNED, SIZE_WORD, 32'hFFFF_FFFF, 16'h0001, 1'b1, 32'h0000_FFFF, 1'b0},
    '{KIND_UNSIGNED, SIZE_BYTE, 32'h0000_FFFF, 16'h00FF, 1'b1, 32'h0000_0001, 1'b0},
    '{KIND_UNSIGNED, SIZE_WORD, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'h0000_0001, 1'b0},
    '{KIND_UNSIGNED, SIZE_WORD, 32'h0000_0000, 16'hFFFF, 1'b1, 32'h0000_0000, 1'b0},
    '{KIND_SIGNED,   SIZE_WORD, 32'h8000_0000, 16'hFFFF, 1'b1, 32'h0000_0000, 1'b0},
    '{KIND_SIGNED,   SIZE_BYTE, 32'h0000_8000, 16'h00FF, 1'b1, 32'h0000_0000, 1'b0},
    '{KIND_SIGNED,   SIZE_BYTE, 32'h0000_FFF9, 16'h0002, 1'b1, 32'h0000_FFFD, 1'b1},
    '{KIND_SIGNED,   SIZE_WORD, 32'hFFFF_FFF9, 16'h0002, 1'b1, 32'hFFFF_FFFD, 1'b1},
    '{KIND_SIGNED,   SIZE_BYTE, 32'h0000_0007, 16'h00FE, 1'b0, 32'h0, 1'b0},
    '{KIND_SIGNED,   SIZE_WORD, 32'h7FFF_FFFF, 16'h7FFF, 1'b0, 32'h0, 1'b0},
    '{KIND_SIGNED,   SIZE_WORD, 32'h8000_0000, 16'h8000, 1'b0, 32'h0, 1'b0},
    '{KIND_SIGNED,   SIZE_WORD, 32'h7FFF_FFFF, 16'h8000, 1'b0, 32'h0, 1'b0},
    '{KIND_SIGNED,   SIZE_BYTE, 32'h0000_7FFF, 16'h0080, 1'b0, 32'h0, 1'b0},
    '{KIND_UNSIGNED, SIZE_WORD, 32'h1234_5678, 16'h1234, 1'b0, 32'h0, 1'b0},
    '{KIND_SIGNED,   SIZE_BYTE, 32'h5555_8001, 16'hAA81, 1'b0, 32'h0, 1'b0},
    '{KIND_UNSIGNED, SIZE_WORD, 32'h0000_0000, 16'h0000, 1'b1, 32'h0000_FFFF, 1'b1}
  };

  integer_divider_with_flags dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Quotient and remainder are formed at twice the operand width, then the low
  // halves are packed; the flag marks remainder bits above the low half or a zero divisor.
  function automatic div_out_t calc_quot_rem(logic kind, logic size, logic [31:0] dvd,
                                             logic [15:0] dsr);
    int unsigned n;
    logic [63:0] hmask;
    logic [63:0] fmask;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] q;
    logic [63:0] r;
    longint      sd;
    longint      ss;
    div_out_t    o;
    n = (size == SIZE_WORD) ? 16 : 8;
    hmask = (64'd1 << n) - 64'd1;
    fmask = (64'd1 << (2 * n)) - 64'd1;
    d = {32'd0, dvd} & fmask;
    s = {48'd0, dsr} & hmask;
    if (s == 64'd0) begin
      q = ~(d >> n) & hmask;
      r = d & hmask;
      o.ov = 1'b1;
    end else begin
      if (kind == KIND_SIGNED) begin
        if (size == SIZE_WORD) begin
          sd = longint'($signed(d[31:0]));
          ss = longint'($signed(s[15:0]));
        end else begin
          sd = longint'($signed(d[15:0]));
          ss = longint'($signed(s[7:0]));
        end
        q = 64'(sd / ss) & fmask;
        r = 64'(sd % ss) & fmask;
      end else begin
        q = d / s;
        r = d % s;
      end
      o.ov = ((r >> n) != 64'd0);
    end
    o.res = 32'(((r & hmask) << n) | (q & hmask));
    return o;
  endfunction

  // Expectations are queued on each input transfer and retired on each output transfer.
  always @(posedge clk_i) begin
    div_out_t want;
    div_out_t got;
    cycles <= cycles + 1;
    if (s_axis_tvalid && s_axis_tready) begin
      if (drv_typed)
        quot_rem_due.push_back(drv_want);
      else
        quot_rem_due.push_back(calc_quot_rem(s_axis_tuser[0], s_axis_tuser[1],
                                             s_axis_tdata[31:0], s_axis_tdata[47:32]));
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got.res = m_axis_tdata;
      got.ov  = m_axis_tuser;
      if (quot_rem_due.size() == 0) begin
        $display("%0t: unexpected result %h ov %b", $time, got.res, got.ov);
        mismatches++;
      end else begin
        want = quot_rem_due.pop_front();
        if (got.res !== want.res) begin
          $display("%0t: packed_result expected %h, actual %h", $time, want.res, got.res);
          mismatches++;
        end
        if (got.ov !== want.ov) begin
          $display("%0t: overflow expected %b, actual %b", $time, want.ov, got.ov);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_div(logic kind, logic size, logic [31:0] dvd, logic [15:0] dsr,
                          bit typed, div_out_t want);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {dsr, dvd};
    s_axis_tuser  = {size, kind};
    drv_typed     = typed;
    drv_want      = want;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (quot_rem_due.size() != 0) @(negedge clk_i);
  endtask

  // Receiver: random stalls per result, bursts without stalls, one long hold-off.
  initial begin
    int gap;
    int taken;
    taken = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready = 1'b0;
        repeat (RX_HOLD) @(negedge clk_i);
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
          m_axis_tready = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
      taken++;
      if (taken % 80 == 0) rx_burst = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    logic        kind;
    logic        size;
    logic [31:0] dvd;
    logic [15:0] dsr;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    drv_typed     = 1'b0;
    drv_want      = '0;
    tx_burst      = 1'b0;
    rx_burst      = 1'b0;
    rx_hold_req   = 1'b0;
    mismatches    = 0;
    cycles        = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (div_rows[i])
      send_div(div_rows[i].kind, div_rows[i].size, div_rows[i].dvd, div_rows[i].dsr,
               div_rows[i].typed, '{div_rows[i].res, div_rows[i].ov});
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 64 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      if (i == 600) rx_hold_req = 1'b1;
      if (i == 1200) drain_results();
      kind = 1'($urandom_range(0, 1));
      size = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0: dvd = 32'h8000_0000;
        1: dvd = 32'h7FFF_FFFF;
        2: dvd = {16'($urandom_range(0, 65535)), 16'h8000};
        3: dvd = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        4: dvd = $urandom_range(0, 65535);
        default: dvd = $urandom;
      endcase
      case ($urandom_range(0, 15))
        0: dsr = {8'($urandom), 8'h00};
        1: dsr = 16'h0000;
        2: dsr = 16'hFFFF;
        3: dsr = {8'($urandom), 8'hFF};
        4: dsr = 16'($urandom_range(1, 4));
        5: dsr = $urandom_range(0, 1) ? 16'h8000 : 16'h0080;
        default: dsr = 16'($urandom);
      endcase
      send_div(kind, size, dvd, dsr, 1'b0, '0);
    end
    s_axis_tvalid = 1'b0;

    while (quot_rem_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/idiv_pkg.sv
rtl/core/idiv_prep.sv
rtl/core/idiv_step.sv
rtl/core/idiv_fin.sv
rtl/core/integer_divider_with_flags.sv
tb/testbench.sv
